FILE: sv/pcq_pkg.sv
// Shared types and constants for the palette color quantizer.
package pcq_pkg;

  localparam logic [8:0] ALPHA_RESET       = 9'd128;
  localparam logic [7:0] TRANSPARENT_INDEX = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MATCH,
    ST_NEAR,
    ST_DONE
  } pcq_state_t;

  typedef enum logic [1:0] {
    RES_TRANSP,
    RES_HIT,
    RES_ADD,
    RES_NEAR
  } pcq_res_sel_t;

  typedef struct packed {
    logic         load;
    logic         scan_start;
    logic         scan_near;
    logic         res_load;
    pcq_res_sel_t res_sel;
    logic         push;
  } pcq_cmd_t;

  typedef struct packed {
    logic transp;
    logic hit;
    logic scan_done;
    logic full;
    logic out_stall;
  } pcq_status_t;

endpackage

FILE: sv/pcq_pixel_if.sv
// Pixel input channel: valid, ready and one RGBA pixel.
interface pcq_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       first_pixel;

  modport source (output valid, red, green, blue, alpha, first_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, first_pixel, output ready);
endinterface

FILE: sv/pcq_result_if.sv
// Result output channel: valid, ready and one palette index result.
interface pcq_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  logic       added_to_palette;
  logic [7:0] colors_in_use;

  modport source (output valid, color_index, added_to_palette, colors_in_use, input ready);
  modport sink   (input valid, color_index, added_to_palette, colors_in_use, output ready);
endinterface

FILE: sv/pcq_ctrl.sv
// Controller state machine that sequences the palette searches.
module pcq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcq_pkg::pcq_status_t status,
  output pcq_pkg::pcq_cmd_t    cmd
);
  import pcq_pkg::*;

  pcq_state_t state;
  pcq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.transp ? ST_DONE : ST_MATCH;
      end
      ST_MATCH: begin
        if (status.hit) begin
          state_next = ST_DONE;
        end else if (status.scan_done) begin
          state_next = status.full ? ST_NEAR : ST_DONE;
        end
      end
      ST_NEAR: begin
        if (status.scan_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_sel    = RES_TRANSP;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        if (status.transp) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_TRANSP;
        end else begin
          cmd.scan_start = 1'b1;
        end
      end
      ST_MATCH: begin
        if (status.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_HIT;
        end else if (status.scan_done) begin
          if (status.full) begin
            cmd.scan_start = 1'b1;
            cmd.scan_near  = 1'b1;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_ADD;
          end
        end
      end
      ST_NEAR: begin
        if (status.scan_done) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_NEAR;
        end
      end
      ST_DONE: begin
        cmd.push = !status.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/pcq_dp.sv
// Datapath: palette memory, scan pipeline, distance search and result registers.
module pcq_dp #(
  parameter int PALETTE_ENTRIES = 255
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic [7:0]           alpha,
  input  logic                 first_pixel,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_data,
  input  pcq_pkg::pcq_cmd_t    cmd,
  output pcq_pkg::pcq_status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           color_index,
  output logic                 added_to_palette,
  output logic [7:0]           colors_in_use
);
  import pcq_pkg::*;

  localparam int         IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [7:0] LAST  = 8'(PALETTE_ENTRIES);

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  logic [23:0] mem [PALETTE_ENTRIES];

  logic [7:0]  pix_r, pix_g, pix_b, pix_a;
  logic [7:0]  count;
  logic [8:0]  threshold;
  logic        scan_near;
  logic        issuing;
  logic [7:0]  scan_addr;
  logic [7:0]  scan_addr_inc;
  logic [7:0]  limit;
  logic [7:0]  scan_limit;
  logic        v1, v2;
  logic [7:0]  idx1, idx2;
  logic [23:0] rdata;
  logic        hit2;
  logic [15:0] sq_r, sq_g, sq_b;
  logic [17:0] sq_sum;
  logic [17:0] min_sum;
  logic [7:0]  best_idx;
  logic [7:0]  res_idx;
  logic        res_added;
  logic        wr_en;

  assign scan_addr_inc = scan_addr + 8'd1;
  assign scan_limit    = cmd.scan_near ? LAST : count;
  assign wr_en         = cmd.res_load && (cmd.res_sel == RES_ADD);
  assign sq_sum        = 18'(sq_r) + 18'(sq_g) + 18'(sq_b);

  assign status.transp    = ({1'b0, pix_a} < threshold);
  assign status.hit       = v2 && hit2;
  assign status.scan_done = !issuing && !v1 && !v2;
  assign status.full      = (count == LAST);
  assign status.out_stall = out_valid && !out_ready;

  // Palette memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= {pix_r, pix_g, pix_b};
    end
    rdata <= mem[scan_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      threshold <= ALPHA_RESET;
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) threshold <= cfg_data;
      if (cmd.load && first_pixel) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + 8'd1;
      end
      if (cmd.scan_start) begin
        issuing <= (scan_limit != 8'd0);
        v1      <= 1'b0;
        v2      <= 1'b0;
      end else if (cmd.res_load) begin
        issuing <= 1'b0;
        v1      <= 1'b0;
        v2      <= 1'b0;
      end else begin
        v1 <= issuing;
        v2 <= v1;
        if (issuing && (scan_addr_inc == limit)) issuing <= 1'b0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r <= red;
      pix_g <= green;
      pix_b <= blue;
      pix_a <= alpha;
    end
    if (cmd.scan_start) begin
      scan_addr <= '0;
      limit     <= scan_limit;
      scan_near <= cmd.scan_near;
      min_sum   <= '1;
      best_idx  <= '0;
    end else begin
      if (issuing) scan_addr <= scan_addr_inc;
      // Strict compare in ascending order keeps the lowest index on a tie.
      if (v2 && scan_near && (sq_sum < min_sum)) begin
        min_sum  <= sq_sum;
        best_idx <= idx2;
      end
    end
    idx1 <= scan_addr;
    idx2 <= idx1;
    hit2 <= (rdata == {pix_r, pix_g, pix_b});
    sq_r <= sq_diff(rdata[23:16], pix_r);
    sq_g <= sq_diff(rdata[15:8], pix_g);
    sq_b <= sq_diff(rdata[7:0], pix_b);
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_TRANSP: begin
          res_idx   <= TRANSPARENT_INDEX;
          res_added <= 1'b0;
        end
        RES_HIT: begin
          res_idx   <= idx2;
          res_added <= 1'b0;
        end
        RES_ADD: begin
          res_idx   <= count;
          res_added <= 1'b1;
        end
        RES_NEAR: begin
          res_idx   <= best_idx;
          res_added <= 1'b0;
        end
        default: begin
          res_idx   <= TRANSPARENT_INDEX;
          res_added <= 1'b0;
        end
      endcase
    end
    if (cmd.push) begin
      color_index      <= res_idx;
      added_to_palette <= res_added;
      colors_in_use    <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LAST)
    else $error("palette count exceeds capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !(out_valid && !out_ready))
    else $error("result pushed over an untaken result");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count < LAST))
    else $error("append into a full palette");

  a_scan_flush: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (!issuing && !v1 && !v2))
    else $error("scan pipeline not flushed after result");

endmodule

FILE: sv/palette_color_quantizer.sv
// Top level of the palette color quantizer: controller, datapath and channel wiring.
//
//   Channel   Direction  Handshake        Contents
//   pixel     in         valid / ready    red, green, blue, alpha, first_pixel
//   result    out        valid / ready    color_index, added_to_palette, colors_in_use
//   cfg       in         cfg_we only      cfg_data = alpha_threshold (9 bits)
//
// One pixel at a time; the palette is walked one entry per cycle through its one read port.
// A transparent pixel skips the palette search; an exact match ends the match pass at that entry,
// a miss appends the color while the palette is not full, and a full-palette miss makes a
// second pass for the nearest-color search. Reset clears the color count and
// result valid and sets the threshold to 128; palette memory is not cleared. A stalled result
// holds back only the next result: the next pixel transfer is still taken in the meantime.
module palette_color_quantizer #(
  parameter int PALETTE_ENTRIES = 255
) (
  input  logic               clk,
  input  logic               rst,
  pcq_pixel_if.sink          pixel,
  pcq_result_if.source       result,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data
);
  import pcq_pkg::*;

  pcq_cmd_t    cmd;
  pcq_status_t status;
  logic        in_ready;

  // The input side is ready only while the controller waits for a new pixel.
  assign pixel.ready = in_ready;

  pcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the palette, the search pipeline and the output register.
  pcq_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .red              (pixel.red),
    .green            (pixel.green),
    .blue             (pixel.blue),
    .alpha            (pixel.alpha),
    .first_pixel      (pixel.first_pixel),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (result.ready),
    .out_valid        (result.valid),
    .color_index      (result.color_index),
    .added_to_palette (result.added_to_palette),
    .colors_in_use    (result.colors_in_use)
  );

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the palette color quantizer with a palette tracker and random traffic.
`timescale 1ns / 100ps

import pcq_pkg::*;

localparam int PALETTE_ENTRIES = 255;

typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       first_pixel;
} pixel_t;

typedef struct {
  logic [7:0] color_index;
  logic       added_to_palette;
  logic [7:0] colors_in_use;
} quant_result_t;

// Tracks the palette the block should be building and queues the index expected for
// every pixel transfer, then checks result transfers against that queue in order.
class palette_tracker;
  logic [23:0]   palette [PALETTE_ENTRIES];
  int unsigned   used;
  logic [8:0]    threshold;
  quant_result_t awaited[$];
  int unsigned   errors;

  function void clear();
    used      = 0;
    threshold = ALPHA_RESET;
    errors    = 0;
    awaited.delete();
  endfunction

  // Works out the index for one pixel and updates the tracked palette.
  function quant_result_t quantize(pixel_t p);
    quant_result_t res;
    logic [23:0]   color;
    bit            found;
    int unsigned   best;
    int unsigned   min_sum;
    int            dr;
    int            dg;
    int            db;
    int unsigned   sq_sum;
    color                = {p.red, p.green, p.blue};
    res.color_index      = TRANSPARENT_INDEX;
    res.added_to_palette = 1'b0;
    found                = 1'b0;
    if (p.first_pixel) used = 0;
    if ({1'b0, p.alpha} >= threshold) begin
      for (int j = 0; j < used; j++) begin
        if (!found && palette[j] == color) begin
          res.color_index = 8'(j);
          found           = 1'b1;
        end
      end
      if (!found) begin
        if (used < PALETTE_ENTRIES) begin
          palette[used]        = color;
          res.color_index      = 8'(used);
          res.added_to_palette = 1'b1;
          used++;
        end else begin
          // Strict less-than keeps the lowest index on a tie.
          best    = 0;
          min_sum = 32'hFFFF_FFFF;
          for (int j = 0; j < PALETTE_ENTRIES; j++) begin
            dr     = int'(palette[j][23:16]) - int'(p.red);
            dg     = int'(palette[j][15:8]) - int'(p.green);
            db     = int'(palette[j][7:0]) - int'(p.blue);
            sq_sum = dr * dr + dg * dg + db * db;
            if (sq_sum < min_sum) begin
              min_sum = sq_sum;
              best    = j;
            end
          end
          res.color_index = 8'(best);
        end
      end
    end
    res.colors_in_use = 8'(used);
    return res;
  endfunction

  function void take_pixel(pixel_t p);
    awaited.push_back(quantize(p));
  endfunction

  function void check_result(quant_result_t got);
    quant_result_t want;
    if (awaited.size() == 0) begin
      $error("result with no pixel outstanding: color_index %0d", got.color_index);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (got.color_index !== want.color_index) begin
      $error("color_index: expected %0d, actual %0d", want.color_index, got.color_index);
      errors++;
    end
    if (got.added_to_palette !== want.added_to_palette) begin
      $error("added_to_palette: expected %0d, actual %0d",
             want.added_to_palette, got.added_to_palette);
      errors++;
    end
    if (got.colors_in_use !== want.colors_in_use) begin
      $error("colors_in_use: expected %0d, actual %0d", want.colors_in_use, got.colors_in_use);
      errors++;
    end
  endfunction
endclass

module tb_top;

  typedef enum int {
    IMG_SMALL,
    IMG_LATTICE,
    IMG_RANDOM_FULL,
    IMG_NOISE
  } image_kind_t;

  localparam int RANDOM_ITEMS    = 900;
  // The last stretch of the run goes without any idling on either side.
  localparam int CALM_ITEMS      = 100;
  localparam int SETTLE_CYCLES   = 12;
  localparam int END_CYCLES      = 40;
  // A full-palette miss takes about two passes over the palette;
  // add the longest stall and gap on each side and take that several times over.
  localparam int WATCHDOG_CYCLES = 4000;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [8:0] cfg_data = ALPHA_RESET;

  pcq_pixel_if  pixel_ch();
  pcq_result_if result_ch();

  palette_color_quantizer #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_ch),
    .result  (result_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  palette_tracker tracker;
  quant_result_t  observed;
  int unsigned    stalled_cycles = 0;
  int unsigned    sent_count     = 0;
  int unsigned    calm_mark      = 32'hFFFF_FFFF;
  bit             calm           = 1'b0;
  int unsigned    gap_pct        = 0;
  int unsigned    stall_pct      = 0;
  int unsigned    stall_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: the receiver drops ready in bursts of random length. The burst rate is
  // chosen per image, and a rate of zero gives long stretches with ready held high.
  initial begin
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        if (stall_left == 0) result_ch.ready <= 1'b1;
      end else if (!calm && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        result_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 13);
      end
    end
  end

  // Every result transfer is checked against the oldest expected index. The same block
  // keeps the watchdog, which counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        observed.color_index      = result_ch.color_index;
        observed.added_to_palette = result_ch.added_to_palette;
        observed.colors_in_use    = result_ch.colors_in_use;
        tracker.check_result(observed);
      end
      if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_CYCLES) begin
          $display("palette_color_quantizer: mismatch");
          $finish;
        end
      end
    end
  end

  function automatic pixel_t make_pixel(int r, int g, int b, int a, bit first);
    pixel_t p;
    p.red         = 8'(r);
    p.green       = 8'(g);
    p.blue        = 8'(b);
    p.alpha       = 8'(a);
    p.first_pixel = first;
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.red         = 8'($urandom);
    p.green       = 8'($urandom);
    p.blue        = 8'($urandom);
    p.alpha       = 8'($urandom);
    p.first_pixel = 1'($urandom);
    return p;
  endfunction

  // An alpha that passes the current threshold; with a threshold above 255 none exists.
  function automatic logic [7:0] opaque_alpha();
    if (tracker.threshold > 9'd255) return 8'($urandom);
    return 8'($urandom_range(int'(tracker.threshold), 255));
  endfunction

  // Points of an 8x8x8 grid with a pitch of 32. Probes on odd multiples of 16 up to 208 sit halfway
  // between grid neighbors, which forces equal distances and exercises the tie rule.
  function automatic pixel_t lattice_pixel(int unsigned point);
    pixel_t p;
    p             = random_pixel();
    p.red         = 8'(((point >> 6) & 7) * 32);
    p.green       = 8'(((point >> 3) & 7) * 32);
    p.blue        = 8'((point & 7) * 32);
    p.first_pixel = 1'b0;
    return p;
  endfunction

  // Offers one pixel and holds it until the transfer. The expected index is worked out
  // right at the transfer, so the tracker is never behind the stimulus.
  task automatic send_pixel(pixel_t p);
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      pixel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.red         <= p.red;
    pixel_ch.green       <= p.green;
    pixel_ch.blue        <= p.blue;
    pixel_ch.alpha       <= p.alpha;
    pixel_ch.first_pixel <= p.first_pixel;
    do @(posedge clk); while (!pixel_ch.ready);
    tracker.take_pixel(p);
    sent_count++;
    calm = (sent_count >= calm_mark);
  endtask

  // Stops offering pixels and waits until every expected result has come back.
  task automatic drain_results();
    pixel_ch.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The threshold is only changed with the block idle and nothing outstanding.
  task automatic write_threshold(logic [8:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we            <= 1'b0;
    tracker.threshold  = value;
  endtask

  // A short image drawn from a small pool of colors, so most pixels hit an entry that is
  // already in the palette. Some pool colors are one bit away from the previous one.
  task automatic run_small_image();
    logic [23:0] pool [24];
    int unsigned pool_size;
    int unsigned length;
    pixel_t      p;
    pool_size = $urandom_range(1, 24);
    length    = $urandom_range(4, 40);
    for (int i = 0; i < pool_size; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) pool[i] = pool[i-1] ^ (24'h1 << $urandom_range(0, 23));
      else pool[i] = 24'($urandom);
    end
    for (int i = 0; i < length; i++) begin
      p = random_pixel();
      if ($urandom_range(0, 9) < 8) {p.red, p.green, p.blue} = pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 19) < 17) p.alpha = opaque_alpha();
      p.first_pixel = (i == 0) || ($urandom_range(0, 39) == 0);
      send_pixel(p);
    end
  endtask

  // Fills the palette to its last entry, then probes the nearest-color search. The grid
  // fill walks the grid with an odd stride, so every point it visits is new.
  task automatic run_full_image(bit on_grid);
    int unsigned start;
    int unsigned stride;
    int unsigned k;
    int unsigned probes;
    pixel_t      p;
    start  = $urandom_range(0, 511);
    stride = $urandom_range(0, 255) * 2 + 1;
    k      = 0;
    while (tracker.used < PALETTE_ENTRIES && k < 2000) begin
      if (on_grid) p = lattice_pixel((start + k * stride) % 512);
      else p = random_pixel();
      p.alpha       = ($urandom_range(0, 19) == 0) ? 8'($urandom) : opaque_alpha();
      p.first_pixel = (k == 0);
      k++;
      send_pixel(p);
    end
    probes = $urandom_range(15, 40);
    for (int i = 0; i < probes; i++) begin
      p             = random_pixel();
      p.first_pixel = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if (on_grid) begin
            p.red   = 8'($urandom_range(0, 15) * 16);
            p.green = 8'($urandom_range(0, 15) * 16);
            p.blue  = 8'($urandom_range(0, 15) * 16);
          end
        end
        5, 6: begin
          // An exact copy of a filled entry still has to be found by the match pass.
          {p.red, p.green, p.blue} = tracker.palette[$urandom_range(0, PALETTE_ENTRIES - 1)];
        end
        default: begin
        end
      endcase
      if ($urandom_range(0, 9) != 0) p.alpha = opaque_alpha();
      send_pixel(p);
    end
  endtask

  // Pixels with every field random, first_pixel included.
  task automatic run_noise_image();
    int unsigned length;
    length = $urandom_range(5, 20);
    for (int i = 0; i < length; i++) send_pixel(random_pixel());
  endtask

  initial begin : stimulus
    int unsigned random_base;
    int unsigned image_no;
    int unsigned pick;
    image_kind_t kind;
    logic [8:0]  next_threshold;

    tracker = new;
    tracker.clear();
    pixel_ch.valid       <= 1'b0;
    pixel_ch.red         <= 8'd0;
    pixel_ch.green       <= 8'd0;
    pixel_ch.blue        <= 8'd0;
    pixel_ch.alpha       <= 8'd0;
    pixel_ch.first_pixel <= 1'b0;
    rst                  <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset threshold of 128: appends, a hit, alpha just below and
    // at the threshold, and the transparent color itself sent as an opaque pixel.
    send_pixel(make_pixel(0, 0, 0, 255, 1'b1));
    send_pixel(make_pixel(255, 255, 255, 255, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 200, 1'b0));
    send_pixel(make_pixel(10, 20, 30, 127, 1'b0));
    send_pixel(make_pixel(255, 0, 0, 128, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 0, 1'b0));
    send_pixel(make_pixel(0, 255, 0, 255, 1'b0));
    send_pixel(make_pixel(0, 0, 255, 255, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 254, 1'b0));
    // A new image that starts on a transparent pixel still clears the count.
    send_pixel(make_pixel(1, 2, 3, 100, 1'b1));
    // Stale entries beyond the cleared count must not match.
    send_pixel(make_pixel(255, 255, 255, 255, 1'b1));
    send_pixel(make_pixel(0, 0, 0, 255, 1'b0));
    // A threshold of zero makes even alpha 0 opaque.
    write_threshold(9'd0);
    send_pixel(make_pixel(0, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(128, 128, 128, 0, 1'b0));
    // Above 255 every pixel is transparent.
    write_threshold(9'd256);
    send_pixel(make_pixel(255, 255, 255, 255, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 255, 1'b1));
    write_threshold(9'd255);
    send_pixel(make_pixel(0, 0, 0, 254, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 255, 1'b0));
    write_threshold(9'd1);
    send_pixel(make_pixel(0, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 1, 1'b0));
    write_threshold(ALPHA_RESET);

    // Random part, one image at a time. The first image always fills the palette on the
    // grid so the nearest-color search and its ties are reached early.
    random_base = sent_count;
    calm_mark   = random_base + RANDOM_ITEMS - CALM_ITEMS;
    image_no    = 0;
    while (sent_count - random_base < RANDOM_ITEMS) begin
      // Threshold changes drain the block, so they stay out of the final idle-free stretch.
      if (image_no != 0 && !calm && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0:       next_threshold = 9'd0;
          1:       next_threshold = 9'd1;
          2:       next_threshold = 9'd255;
          3:       next_threshold = 9'd256;
          4:       next_threshold = ALPHA_RESET;
          default: next_threshold = 9'($urandom_range(0, 256));
        endcase
        write_threshold(next_threshold);
      end
      pick = $urandom_range(0, 99);
      if (image_no == 0)  kind = IMG_LATTICE;
      else if (pick < 6)  kind = IMG_LATTICE;
      else if (pick < 12) kind = IMG_RANDOM_FULL;
      else if (pick < 27) kind = IMG_NOISE;
      else                kind = IMG_SMALL;
      // With every pixel transparent the palette can never fill.
      if (tracker.threshold > 9'd255 && (kind == IMG_LATTICE || kind == IMG_RANDOM_FULL)) begin
        kind = IMG_SMALL;
      end
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        default: gap_pct = 25;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 5;
        default: stall_pct = 25;
      endcase
      case (kind)
        IMG_LATTICE:     run_full_image(1'b1);
        IMG_RANDOM_FULL: run_full_image(1'b0);
        IMG_NOISE:       run_noise_image();
        default:         run_small_image();
      endcase
      image_no++;
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("palette_color_quantizer: match");
    end else begin
      $display("palette_color_quantizer: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pcq_pkg.sv
sv/pcq_pixel_if.sv
sv/pcq_result_if.sv
sv/pcq_ctrl.sv
sv/pcq_dp.sv
sv/palette_color_quantizer.sv
sim/tb_top.sv
